// ----- rtl/core/lld_pkg.sv -----
package lld_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_QUEUED_A    = 3'd0,
        ST_QUEUED_B    = 3'd1,
        ST_POPPED      = 3'd2,
        ST_NOTHING     = 3'd3,
        ST_UNSUPPORTED = 3'd4,
        ST_FULL        = 3'd5
    } t_status;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [1:0] CLASS_A = 2'd0;
    localparam logic [1:0] CLASS_B = 2'd1;

    // queue commands from the dispatcher
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    // queue status back to the dispatcher
    typedef struct packed {
        logic full;
        logic empty;
        logic pending_next;
    } t_q_stat;

endpackage

// ----- rtl/core/lld_cell.sv -----
module lld_cell #(
    parameter int DW = 40
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic [DW-1:0] i_load_data,
    input  logic          i_shift,
    input  logic [DW-1:0] i_next_data,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_data;

    // load on push at the fill position, else take the neighbor's entry on pop
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- rtl/core/lld_queue.sv -----
module lld_queue
    import lld_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = 16,
    parameter int MW    = 8,
    parameter int TAGW  = 16,
    parameter int TW    = CW + $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_q_ctrl         i_ctrl,
    input  logic [CW-1:0]   i_cost,
    input  logic [MW-1:0]   i_ids,
    input  logic [TAGW-1:0] i_tag,
    output logic [MW-1:0]   o_head_ids,
    output logic [TAGW-1:0] o_head_tag,
    output logic [TW-1:0]   o_total,
    output t_q_stat         o_stat
);

    localparam int NW = $clog2(DEPTH + 1);
    localparam int DW = CW + MW + TAGW;

    logic [NW-1:0] r_count;
    logic [NW-1:0] n_count;
    logic [TW-1:0] r_total;
    logic [TW-1:0] n_total;
    logic          w_full;
    logic          w_empty;
    logic          w_do_push;
    logic          w_do_pop;
    logic [DW-1:0] w_push_data;
    logic [CW-1:0] w_head_cost;
    logic [DW-1:0] w_cell_q [DEPTH];

    assign w_full      = (r_count == NW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_do_push   = i_ctrl.push && !w_full;
    assign w_do_pop    = i_ctrl.pop && !w_empty;
    assign w_push_data = {i_cost, i_ids, i_tag};

    // head lives in cell 0; pops shift the whole row toward it
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DW-1:0] w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_q[g+1];
        end
        lld_cell #(
            .DW(DW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (w_do_push && (r_count == NW'(g))),
            .i_load_data (w_push_data),
            .i_shift     (w_do_pop),
            .i_next_data (w_next),
            .o_data      (w_cell_q[g])
        );
    end

    always_comb begin
        n_count = r_count;
        n_total = r_total;
        if (w_do_push) begin
            n_count = r_count + 1'b1;
            n_total = r_total + TW'(i_cost);
        end else if (w_do_pop) begin
            n_count = r_count - 1'b1;
            n_total = r_total - TW'(w_head_cost);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    assign {w_head_cost, o_head_ids, o_head_tag} = w_cell_q[0];
    assign o_total             = r_total;
    assign o_stat.full         = w_full;
    assign o_stat.empty        = w_empty;
    assign o_stat.pending_next = (n_count != '0);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count above depth");
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("empty queue with nonzero load");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not advance count");
`endif

endmodule

// ----- rtl/core/least_load_two_queue_dispatcher.sv -----
// Two-class least-load dispatcher. Each start transfer is a push (i_func = 0) or a
// pop (i_func = 1) and yields exactly one result, shown on o_status/o_out_tag/
// o_work_pending for one cycle with o_done high, in the cycle right after the
// transfer. The block takes one item per clock: busy is never raised; the two
// running load totals and each queue's fill count and head cell are all that
// an item needs, so the next item sees the updated state on the following edge.
// Since the receiver cannot stall, it must sample o_done every cycle.
// Each queue is a row of QUEUE_DEPTH cells with the head in cell 0; a push
// writes the cell at the fill count, a pop shifts every cell one place toward
// the head. A push that both classes accept goes to class A only when
// load_a + cost_a < load_b + cost_b, else to class B; a push into a full queue
// is dropped with status full, a push that no class accepts gets unsupported.
// A pop returns the head tag only if the named queue holds a task and the
// head's id mask has the popping id; otherwise status nothing and tag zero.
module least_load_two_queue_dispatcher
    import lld_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int DEVICE_IDS  = 8,
    parameter int COST_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [15:0] i_cost_a,
    input  logic [15:0] i_cost_b,
    input  logic        i_runs_on_a,
    input  logic        i_runs_on_b,
    input  logic [7:0]  i_allowed_ids,
    input  logic [15:0] i_task_tag,
    input  logic [1:0]  i_pop_class,
    input  logic [2:0]  i_pop_id,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_tag,
    output logic        o_work_pending
);

    // costs arrive on 16-bit ports, so only the low bits up to 16 count
    localparam int CW   = (COST_BITS < 16) ? COST_BITS : 16;
    // id mask bits beyond eight can never match a 3-bit id
    localparam int MW   = (DEVICE_IDS < 8) ? DEVICE_IDS : 8;
    localparam int TAGW = 16;
    localparam int TW   = CW + $clog2(QUEUE_DEPTH + 1);

    logic            w_take;
    t_q_ctrl         w_ctrl_a;
    t_q_ctrl         w_ctrl_b;
    t_q_stat         w_stat_a;
    t_q_stat         w_stat_b;
    logic [CW-1:0]   w_cost_a;
    logic [CW-1:0]   w_cost_b;
    logic [MW-1:0]   w_ids;
    logic [MW-1:0]   w_head_ids_a;
    logic [MW-1:0]   w_head_ids_b;
    logic [TAGW-1:0] w_head_tag_a;
    logic [TAGW-1:0] w_head_tag_b;
    logic [TW-1:0]   w_total_a;
    logic [TW-1:0]   w_total_b;
    logic [TW:0]     w_sum_a;
    logic [TW:0]     w_sum_b;
    logic [7:0]      w_mask_a;
    logic [7:0]      w_mask_b;
    logic            w_to_a;

    t_status         n_status;
    logic [15:0]     n_tag;
    logic            r_done;
    t_status         r_status;
    logic [15:0]     r_tag;
    logic            r_pending;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_cost_a = i_cost_a[CW-1:0];
    assign w_cost_b = i_cost_b[CW-1:0];
    assign w_ids    = i_allowed_ids[MW-1:0];

    // least-load choice on the running totals
    assign w_sum_a = (TW+1)'(w_total_a) + (TW+1)'(w_cost_a);
    assign w_sum_b = (TW+1)'(w_total_b) + (TW+1)'(w_cost_b);
    assign w_to_a  = (i_runs_on_a && i_runs_on_b) ? (w_sum_a < w_sum_b) : i_runs_on_a;

    assign w_mask_a = 8'(w_head_ids_a);
    assign w_mask_b = 8'(w_head_ids_b);

    always_comb begin
        w_ctrl_a = '0;
        w_ctrl_b = '0;
        n_status = ST_NOTHING;
        n_tag    = '0;
        if (i_func == FUNC_PUSH) begin
            if (!i_runs_on_a && !i_runs_on_b) begin
                n_status = ST_UNSUPPORTED;
            end else if (w_to_a) begin
                n_status      = w_stat_a.full ? ST_FULL : ST_QUEUED_A;
                w_ctrl_a.push = w_take && !w_stat_a.full;
            end else begin
                n_status      = w_stat_b.full ? ST_FULL : ST_QUEUED_B;
                w_ctrl_b.push = w_take && !w_stat_b.full;
            end
        end else begin
            case (i_pop_class)
                CLASS_A: begin
                    if (!w_stat_a.empty && w_mask_a[i_pop_id]) begin
                        n_status     = ST_POPPED;
                        n_tag        = w_head_tag_a;
                        w_ctrl_a.pop = w_take;
                    end
                end
                CLASS_B: begin
                    if (!w_stat_b.empty && w_mask_b[i_pop_id]) begin
                        n_status     = ST_POPPED;
                        n_tag        = w_head_tag_b;
                        w_ctrl_b.pop = w_take;
                    end
                end
                default: begin
                    n_status = ST_NOTHING;
                end
            endcase
        end
    end

    lld_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW),
        .MW    (MW),
        .TAGW  (TAGW),
        .TW    (TW)
    ) u_queue_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl_a),
        .i_cost      (w_cost_a),
        .i_ids       (w_ids),
        .i_tag       (i_task_tag),
        .o_head_ids  (w_head_ids_a),
        .o_head_tag  (w_head_tag_a),
        .o_total     (w_total_a),
        .o_stat      (w_stat_a)
    );

    lld_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW),
        .MW    (MW),
        .TAGW  (TAGW),
        .TW    (TW)
    ) u_queue_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl_b),
        .i_cost      (w_cost_b),
        .i_ids       (w_ids),
        .i_tag       (i_task_tag),
        .o_head_ids  (w_head_ids_b),
        .o_head_tag  (w_head_tag_b),
        .o_total     (w_total_b),
        .o_stat      (w_stat_b)
    );

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_take;
        end
    end

    // result payload, captured with the transfer
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status  <= n_status;
            r_tag     <= n_tag;
            r_pending <= w_stat_a.pending_next || w_stat_b.pending_next;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_out_tag      = r_tag;
    assign o_work_pending = r_pending;

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("transfer without result");
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_POPPED)) |-> (o_out_tag == '0))
        else $error("tag set on non-pop result");
    a_queued_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_status == ST_QUEUED_A) || (o_status == ST_QUEUED_B)
                    || (o_status == ST_FULL))) |-> o_work_pending)
        else $error("queued task but no work pending");
    a_single_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl_a.push && w_ctrl_b.push) && !(w_ctrl_a.pop && w_ctrl_b.pop))
        else $error("both queues commanded at once");
`endif

endmodule
